[design/rthp_pkg.sv]
// Shared types, constants and lookup functions for the radiotap header parser.
package rthp_pkg;

  localparam int unsigned NumFields = 14;
  localparam int unsigned CursorW   = 4;

  localparam logic [CursorW-1:0] FldTsf     = 4'd0;
  localparam logic [CursorW-1:0] FldFlags   = 4'd1;
  localparam logic [CursorW-1:0] FldRate    = 4'd2;
  localparam logic [CursorW-1:0] FldChannel = 4'd3;
  localparam logic [CursorW-1:0] FldSignal  = 4'd5;
  localparam logic [CursorW-1:0] FldNoise   = 4'd6;
  localparam logic [CursorW-1:0] FldAntenna = 4'd11;
  localparam logic [CursorW-1:0] FldNone    = 4'd14;

  localparam logic [15:0] OffLenLo  = 16'd2;
  localparam logic [15:0] OffLenHi  = 16'd3;
  localparam logic [15:0] OffWord0  = 16'd7;
  localparam logic [15:0] OffMax    = 16'hFFFF;

  localparam int unsigned Freq24First = 2412;
  localparam int unsigned Freq24Last  = 2477;
  localparam int unsigned Freq24Step  = 5;
  localparam int unsigned Chan24Count = (Freq24Last - Freq24First) / Freq24Step + 1;

  localparam logic [1:0] PreambleLong  = 2'd1;
  localparam logic [1:0] PreambleShort = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       header_start;
  } rthp_beat_t;

  typedef struct packed {
    logic        tsf_present;
    logic [63:0] tsf;
    logic [1:0]  preamble;
    logic        rate_present;
    logic [10:0] data_rate;
    logic        channel_present;
    logic [7:0]  channel_number;
    logic [8:0]  signal_level;
    logic [8:0]  noise_level;
    logic        antenna_present;
    logic [7:0]  antenna_index;
  } rthp_hold_t;

  typedef struct packed {
    rthp_hold_t  hold;
    logic [15:0] header_length;
  } rthp_result_t;

  function automatic logic [3:0] field_size(input logic [CursorW-1:0] fld);
    logic [3:0] sz;
    case (fld)
      4'd0:    sz = 4'd8;
      4'd3:    sz = 4'd4;
      4'd4, 4'd7, 4'd8, 4'd9: sz = 4'd2;
      default: sz = 4'd1;
    endcase
    return sz;
  endfunction

  function automatic logic [7:0] freq_to_channel(input logic [15:0] f);
    logic [7:0] ch;
    ch = 8'd0;
    for (int k = 0; k < Chan24Count; k++) begin
      if (f == 16'(Freq24First + Freq24Step * k)) ch = 8'(k + 1);
    end
    case (f)
      16'd5170: ch = 8'd34;
      16'd5180: ch = 8'd36;
      16'd5190: ch = 8'd38;
      16'd5200: ch = 8'd40;
      16'd5210: ch = 8'd42;
      16'd5220: ch = 8'd44;
      16'd5230: ch = 8'd46;
      16'd5240: ch = 8'd48;
      16'd5260: ch = 8'd52;
      16'd5280: ch = 8'd56;
      16'd5300: ch = 8'd60;
      16'd5320: ch = 8'd64;
      16'd5745: ch = 8'd149;
      16'd5765: ch = 8'd153;
      16'd5785: ch = 8'd157;
      16'd5805: ch = 8'd161;
      default:  ch = ch;
    endcase
    return ch;
  endfunction

endpackage

[design/rthp_input_stage.sv]
// Input register stage: holds one header byte beat ahead of the parser.
module rthp_input_stage
  import rthp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  rthp_beat_t in_beat,
  input  logic       advance,
  output logic       stage_valid,
  output rthp_beat_t stage_beat
);

  logic       valid_r;
  rthp_beat_t beat_r;

  assign in_ready    = !valid_r || advance;
  assign stage_valid = valid_r;
  assign stage_beat  = beat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

endmodule

[design/rthp_field_parser.sv]
// Parse state and per-byte field decode; flags a result on the last header byte.
module rthp_field_parser
  import rthp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  rthp_beat_t   beat,
  output logic         emit,
  output rthp_result_t result
);

  logic [15:0]         offset_r, offset_nxt;
  logic [15:0]         length_r, length_nxt;
  logic [NumFields-1:0] present_r, present_nxt;
  logic                ext_r, ext_nxt;
  logic [CursorW-1:0]  cursor_r, cursor_nxt;
  logic [2:0]          fidx_r, fidx_nxt;
  logic [63:0]         shift_r, shift_nxt;
  rthp_hold_t          hold_r, hold_nxt;
  logic                done_r, done_nxt;

  always_comb begin
    logic [15:0]        off;
    logic [7:0]         b;
    logic [63:0]        v;
    logic               found;
    logic [CursorW-1:0] sel;

    b          = beat.data_byte;
    off        = offset_r;
    offset_nxt = offset_r;
    length_nxt = length_r;
    present_nxt = present_r;
    ext_nxt    = ext_r;
    cursor_nxt = cursor_r;
    fidx_nxt   = fidx_r;
    shift_nxt  = shift_r;
    hold_nxt   = hold_r;
    done_nxt   = done_r;
    emit       = 1'b0;
    v          = '0;
    found      = 1'b0;
    sel        = FldNone;

    if (beat.header_start) begin
      off         = '0;
      offset_nxt  = '0;
      length_nxt  = '0;
      present_nxt = '0;
      ext_nxt     = 1'b0;
      cursor_nxt  = '0;
      fidx_nxt    = '0;
      shift_nxt   = '0;
      hold_nxt    = '0;
      done_nxt    = 1'b0;
    end

    if (!done_nxt) begin
      if (off == OffLenLo) begin
        length_nxt = {8'd0, b};
      end else if (off == OffLenHi) begin
        length_nxt = {b, length_nxt[7:0]};
        ext_nxt    = 1'b1;
        fidx_nxt   = '0;
        shift_nxt  = '0;
      end else if (off > OffLenHi) begin
        if (ext_nxt) begin
          v = shift_nxt | (64'(b) << {fidx_nxt[1:0], 3'b000});
          if (fidx_nxt >= 3'd3) begin
            if (off == OffWord0) present_nxt = v[NumFields-1:0];
            ext_nxt   = b[7];
            fidx_nxt  = '0;
            shift_nxt = '0;
          end else begin
            fidx_nxt  = fidx_nxt + 3'd1;
            shift_nxt = v;
          end
        end else begin
          for (int k = 0; k < NumFields; k++) begin
            if (!found && (CursorW'(k) >= cursor_nxt) && present_nxt[k]) begin
              found = 1'b1;
              sel   = CursorW'(k);
            end
          end
          if (!found) begin
            cursor_nxt = FldNone;
          end else begin
            v = shift_nxt | (64'(b) << {fidx_nxt, 3'b000});
            if (({1'b0, fidx_nxt} + 4'd1) >= field_size(sel)) begin
              case (sel)
                FldTsf: begin
                  hold_nxt.tsf_present = 1'b1;
                  hold_nxt.tsf         = v;
                end
                FldFlags: hold_nxt.preamble = v[1] ? PreambleShort : PreambleLong;
                FldRate: begin
                  hold_nxt.rate_present = 1'b1;
                  hold_nxt.data_rate    = {1'b0, v[7:0], 2'b00} + {3'b000, v[7:0]};
                end
                FldChannel: begin
                  hold_nxt.channel_present = 1'b1;
                  hold_nxt.channel_number  = freq_to_channel(v[15:0]);
                end
                FldSignal: hold_nxt.signal_level = {~v[7], v[7:0]};
                FldNoise:  hold_nxt.noise_level  = {~v[7], v[7:0]};
                FldAntenna: begin
                  hold_nxt.antenna_present = 1'b1;
                  hold_nxt.antenna_index   = v[7:0];
                end
                default: hold_nxt = hold_nxt;
              endcase
              cursor_nxt = sel + CursorW'(1);
              fidx_nxt   = '0;
              shift_nxt  = '0;
            end else begin
              cursor_nxt = sel;
              fidx_nxt   = fidx_nxt + 3'd1;
              shift_nxt  = v;
            end
          end
        end
      end

      if (off != OffMax) offset_nxt = off + 16'd1;

      if ((off >= OffLenHi) && (({1'b0, off} + 17'd1) >= {1'b0, length_nxt})) begin
        done_nxt = 1'b1;
        emit     = 1'b1;
      end
    end
  end

  assign result.hold          = hold_nxt;
  assign result.header_length = length_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= '0;
      length_r  <= '0;
      present_r <= '0;
      ext_r     <= 1'b0;
      cursor_r  <= '0;
      fidx_r    <= '0;
      shift_r   <= '0;
      hold_r    <= '0;
      done_r    <= 1'b0;
    end else if (go) begin
      offset_r  <= offset_nxt;
      length_r  <= length_nxt;
      present_r <= present_nxt;
      ext_r     <= ext_nxt;
      cursor_r  <= cursor_nxt;
      fidx_r    <= fidx_nxt;
      shift_r   <= shift_nxt;
      hold_r    <= hold_nxt;
      done_r    <= done_nxt;
    end
  end

endmodule

[design/radiotap_header_parser_unit.sv]
// Top level of the radiotap header parser: input stage, field parser, result register.
//
// Usage: radiotap header bytes enter on the in_ channel, one byte per beat,
// with in_header_start high on byte 0 of each header. The parser reads the
// length and present bitmap, walks the selected fields and gives one result
// beat on the out_ channel when the last header byte (per the length field)
// has been taken; bytes beyond that are dropped until the next header start.
// Throughput: one byte per cycle while no result waits on out_ready; the
// one-byte decode step lies between the input register and the result register.
// Output: a result beat shows on out_valid once the last byte has passed the
// input register and then the result register.
// Stall: while a result waits on out_ready the result register holds; the
// input register takes one more byte only if it is empty, then in_ready stays low until the
// result is taken.
// Reset: rst_n (synchronous, active low) empties both registers and clears
// the parse state; the first byte after reset is treated as byte 0.
module radiotap_header_parser_unit
  import rthp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_header_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tsf_present,
  output logic [63:0] out_tsf,
  output logic [1:0]  out_preamble,
  output logic        out_rate_present,
  output logic [10:0] out_data_rate,
  output logic        out_channel_present,
  output logic [7:0]  out_channel_number,
  output logic [8:0]  out_signal_level,
  output logic [8:0]  out_noise_level,
  output logic        out_antenna_present,
  output logic [7:0]  out_antenna_index,
  output logic [15:0] out_header_length
);

  rthp_beat_t   in_beat;
  rthp_beat_t   stage_beat;
  logic         stage_valid;
  logic         out_free;
  logic         advance;
  logic         emit;
  rthp_result_t result;
  logic         out_valid_r;
  rthp_result_t result_r;

  assign in_beat.data_byte    = in_data_byte;
  assign in_beat.header_start = in_header_start;

  assign out_free = !out_valid_r || out_ready;
  assign advance  = stage_valid && out_free;

  rthp_input_stage u_input (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_beat     (in_beat),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_beat  (stage_beat)
  );

  rthp_field_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (advance),
    .beat   (stage_beat),
    .emit   (emit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_tsf_present     = result_r.hold.tsf_present;
  assign out_tsf             = result_r.hold.tsf;
  assign out_preamble        = result_r.hold.preamble;
  assign out_rate_present    = result_r.hold.rate_present;
  assign out_data_rate       = result_r.hold.data_rate;
  assign out_channel_present = result_r.hold.channel_present;
  assign out_channel_number  = result_r.hold.channel_number;
  assign out_signal_level    = result_r.hold.signal_level;
  assign out_noise_level     = result_r.hold.noise_level;
  assign out_antenna_present = result_r.hold.antenna_present;
  assign out_antenna_index   = result_r.hold.antenna_index;
  assign out_header_length   = result_r.header_length;

endmodule

[dv/testbench.sv]
// Testbench for radiotap_header_parser_unit: header stimulus, parse prediction, result checks.
module testbench
  import rthp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {FillRandom, FillZero, FillOnes} fill_t;

  localparam int FieldBytes [NumFields] = '{8, 1, 1, 4, 2, 1, 1, 2, 2, 2, 1, 1, 1, 1};
  localparam logic [15:0] Freq5g [16] = '{16'd5170, 16'd5180, 16'd5190, 16'd5200,
                                          16'd5210, 16'd5220, 16'd5230, 16'd5240,
                                          16'd5260, 16'd5280, 16'd5300, 16'd5320,
                                          16'd5745, 16'd5765, 16'd5785, 16'd5805};
  localparam int CycleLimit = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_header_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_tsf_present;
  logic [63:0] out_tsf;
  logic [1:0]  out_preamble;
  logic        out_rate_present;
  logic [10:0] out_data_rate;
  logic        out_channel_present;
  logic [7:0]  out_channel_number;
  logic [8:0]  out_signal_level;
  logic [8:0]  out_noise_level;
  logic        out_antenna_present;
  logic [7:0]  out_antenna_index;
  logic [15:0] out_header_length;

  radiotap_header_parser_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_header_start     (in_header_start),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_tsf_present     (out_tsf_present),
    .out_tsf             (out_tsf),
    .out_preamble        (out_preamble),
    .out_rate_present    (out_rate_present),
    .out_data_rate       (out_data_rate),
    .out_channel_present (out_channel_present),
    .out_channel_number  (out_channel_number),
    .out_signal_level    (out_signal_level),
    .out_noise_level     (out_noise_level),
    .out_antenna_present (out_antenna_present),
    .out_antenna_index   (out_antenna_index),
    .out_header_length   (out_header_length)
  );

  rthp_beat_t   pending_beats [$];
  rthp_result_t results_due [$];
  rthp_beat_t   next_beat;
  rthp_result_t want_res;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_queued = 0;
  int headers_queued = 0;
  int beats_in = 0;
  int results_checked = 0;
  int err_count = 0;
  int cycles = 0;
  bit in_fire = 1'b0;

  // parser shadow state
  logic [15:0] rx_offset;
  logic [15:0] rx_length;
  logic [31:0] rx_present;
  bit          rx_in_bitmap;
  logic [3:0]  rx_cursor;
  logic [2:0]  rx_byte_idx;
  logic [63:0] rx_shift;
  rthp_hold_t  rx_hold;
  logic [15:0] rx_freq;
  bit          rx_done;

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic clear_parse();
    rx_offset    = '0;
    rx_length    = '0;
    rx_present   = '0;
    rx_in_bitmap = 1'b0;
    rx_cursor    = '0;
    rx_byte_idx  = '0;
    rx_shift     = '0;
    rx_hold      = '0;
    rx_freq      = '0;
    rx_done      = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic hs);
    logic [15:0]  off;
    logic [7:0]   ch;
    int           f;
    rthp_result_t r;
    if (hs) clear_parse();
    if (!rx_done) begin
      off = rx_offset;
      if (off == OffLenLo) begin
        rx_length = {8'd0, b};
      end else if (off == OffLenHi) begin
        rx_length[15:8] = b;
        rx_in_bitmap = 1'b1;
        rx_byte_idx  = '0;
        rx_shift     = '0;
      end else if (off > OffLenHi) begin
        if (rx_in_bitmap) begin
          rx_shift |= 64'(b) << {1'b0, rx_byte_idx[1:0], 3'b000};
          if (rx_byte_idx >= 3'd3) begin
            if (off == OffWord0) rx_present = rx_shift[31:0];
            rx_in_bitmap = rx_shift[31];
            rx_byte_idx  = '0;
            rx_shift     = '0;
          end else begin
            rx_byte_idx++;
          end
        end else begin
          while (rx_cursor < NumFields && !rx_present[rx_cursor]) rx_cursor++;
          if (rx_cursor < NumFields) begin
            rx_shift |= 64'(b) << {rx_byte_idx, 3'b000};
            if (int'(rx_byte_idx) + 1 >= FieldBytes[rx_cursor]) begin
              case (rx_cursor)
                FldTsf: begin
                  rx_hold.tsf_present = 1'b1;
                  rx_hold.tsf = rx_shift;
                end
                FldFlags: rx_hold.preamble = rx_shift[1] ? PreambleShort : PreambleLong;
                FldRate: begin
                  rx_hold.rate_present = 1'b1;
                  rx_hold.data_rate = 11'(rx_shift[7:0]) * 11'd5;
                end
                FldChannel: begin
                  rx_freq = rx_shift[15:0];
                  f = int'(rx_freq);
                  if (f >= 2412 && f <= 2477 && (f - 2412) % 5 == 0) begin
                    ch = 8'((f - 2412) / 5 + 1);
                  end else begin
                    case (f)
                      5170: ch = 8'd34;   5180: ch = 8'd36;   5190: ch = 8'd38;
                      5200: ch = 8'd40;   5210: ch = 8'd42;   5220: ch = 8'd44;
                      5230: ch = 8'd46;   5240: ch = 8'd48;   5260: ch = 8'd52;
                      5280: ch = 8'd56;   5300: ch = 8'd60;   5320: ch = 8'd64;
                      5745: ch = 8'd149;  5765: ch = 8'd153;  5785: ch = 8'd157;
                      5805: ch = 8'd161;
                      default: ch = 8'd0;
                    endcase
                  end
                  rx_hold.channel_present = 1'b1;
                  rx_hold.channel_number = ch;
                end
                FldSignal: rx_hold.signal_level = {~rx_shift[7], rx_shift[7:0]};
                FldNoise: rx_hold.noise_level = {~rx_shift[7], rx_shift[7:0]};
                FldAntenna: begin
                  rx_hold.antenna_present = 1'b1;
                  rx_hold.antenna_index = rx_shift[7:0];
                end
                default: ;
              endcase
              rx_cursor++;
              rx_byte_idx = '0;
              rx_shift    = '0;
            end else begin
              rx_byte_idx++;
            end
          end
        end
      end
      if (rx_offset != OffMax) rx_offset++;
      if (off >= OffLenHi && {1'b0, off} + 17'd1 >= {1'b0, rx_length}) begin
        rx_done = 1'b1;
        r.hold = rx_hold;
        r.header_length = rx_length;
        results_due.push_back(r);
      end
    end
  endtask

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s: got %0h, want %0h",
                             results_checked, name, got, want));
  endtask

  // monitor: outputs sampled at the rising edge
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && in_ready;
    if (rst_n) begin
      cycles++;
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_error("result beat with no header pending");
        end else begin
          want_res = results_due.pop_front();
          check_field("tsf_present", out_tsf_present, want_res.hold.tsf_present);
          check_field("tsf", out_tsf, want_res.hold.tsf);
          check_field("preamble", out_preamble, want_res.hold.preamble);
          check_field("rate_present", out_rate_present, want_res.hold.rate_present);
          check_field("data_rate", out_data_rate, want_res.hold.data_rate);
          check_field("channel_present", out_channel_present,
                      want_res.hold.channel_present);
          check_field("channel_number", out_channel_number, want_res.hold.channel_number);
          check_field("signal_level", out_signal_level, want_res.hold.signal_level);
          check_field("noise_level", out_noise_level, want_res.hold.noise_level);
          check_field("antenna_present", out_antenna_present,
                      want_res.hold.antenna_present);
          check_field("antenna_index", out_antenna_index, want_res.hold.antenna_index);
          check_field("header_length", out_header_length, want_res.header_length);
          results_checked++;
        end
      end
      if (in_fire) begin
        beats_in++;
        parse_byte(in_data_byte, in_header_start);
      end
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, results_due.size());
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // driver: inputs change at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_beat = pending_beats.pop_front();
        in_valid        <= 1'b1;
        in_data_byte    <= next_beat.data_byte;
        in_header_start <= next_beat.header_start;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic push_beat(input logic [7:0] b, input logic hs);
    rthp_beat_t bt;
    bt.data_byte = b;
    bt.header_start = hs;
    pending_beats.push_back(bt);
    bytes_queued++;
  endtask

  function automatic logic [7:0] fill_byte(input fill_t fill);
    case (fill)
      FillZero: return 8'h00;
      FillOnes: return 8'hFF;
      default:  return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_freq();
    case ($urandom_range(0, 4))
      0: return 16'(2412 + 5 * $urandom_range(0, 13));
      1: return 16'($urandom_range(2400, 2490));
      2: return Freq5g[$urandom_range(0, 15)];
      3: return 16'($urandom_range(5160, 5820));
      default: return 16'($urandom);
    endcase
  endfunction

  // len_force >= 0 overrides the length field; n_send < 0 sends the length plus zero to three
  // bytes past the end, capped at the bytes built
  task automatic queue_header(input logic [31:0] present, input int n_ext, input int len_adj,
                              input int len_force, input int n_send, input fill_t fill,
                              input bit first_start, input logic [15:0] freq);
    logic [7:0]  hdr [$];
    logic [31:0] word;
    int          natural;
    int          len;
    int          count;
    natural = 8 + 4 * n_ext;
    for (int k = 0; k < NumFields; k++) if (present[k]) natural += FieldBytes[k];
    len = (len_force >= 0) ? len_force : natural + len_adj;
    if (len < 0) len = 0;
    hdr.push_back(fill_byte(fill));
    hdr.push_back(fill_byte(fill));
    hdr.push_back(8'(len));
    hdr.push_back(8'(len >> 8));
    word = present;
    word[31] = (n_ext > 0);
    for (int j = 0; j < 4; j++) hdr.push_back(word[8*j +: 8]);
    for (int e = 0; e < n_ext; e++) begin
      word = $urandom;
      word[31] = (e < n_ext - 1);
      for (int j = 0; j < 4; j++) hdr.push_back(word[8*j +: 8]);
    end
    for (int k = 0; k < NumFields; k++) begin
      if (present[k]) begin
        for (int j = 0; j < FieldBytes[k]; j++) begin
          if (k == FldChannel && j < 2) hdr.push_back(freq[8*j +: 8]);
          else hdr.push_back(fill_byte(fill));
        end
      end
    end
    repeat (24) hdr.push_back(8'($urandom));
    count = (n_send < 0) ? len + $urandom_range(0, 3) : n_send;
    if (count > hdr.size()) count = hdr.size();
    for (int i = 0; i < count; i++) push_beat(hdr[i], (i == 0) && first_start);
    headers_queued++;
  endtask

  task automatic queue_random(input int target);
    int          stop;
    int          pick;
    int          n_ext;
    logic [31:0] present;
    fill_t       fill;
    stop = bytes_queued + target;
    while (bytes_queued < stop) begin
      pick = $urandom_range(0, 99);
      present = ($urandom_range(0, 4) == 0) ? ($urandom & 32'h7FFF_FFFF)
                                             : ($urandom & 32'h0000_3FFF);
      n_ext = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      fill = ($urandom_range(0, 9) == 0) ? FillZero :
             (($urandom_range(0, 9) == 0) ? FillOnes : FillRandom);
      if (pick < 5) begin
        repeat ($urandom_range(1, 6)) push_beat(8'($urandom), $urandom_range(0, 7) == 0);
      end else if (pick < 70) begin
        queue_header(present, n_ext, 0, -1, -1, fill, 1'b1, pick_freq());
      end else if (pick < 80) begin
        queue_header(present, n_ext, -$urandom_range(1, 12), -1, -1, fill, 1'b1,
                     pick_freq());
      end else if (pick < 88) begin
        queue_header(present, n_ext, $urandom_range(1, 20), -1, -1, fill, 1'b1,
                     pick_freq());
      end else if (pick < 96) begin
        queue_header(present, n_ext, 0, -1, $urandom_range(1, 30), fill, 1'b1,
                     pick_freq());
      end else begin
        queue_header(present, n_ext, 0, $urandom_range(0, 65535), $urandom_range(1, 40),
                     fill, 1'b1, pick_freq());
      end
    end
  endtask

  initial begin
    clear_parse();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 16;
    recv_idle_pct = 55;
    // first header has no start flag: taken as byte 0 after reset
    queue_header(32'h0000_3FFF, 0, 0, -1, -1, FillOnes, 1'b0, 16'd2412);
    queue_header(32'h0000_3FFF, 0, 0, -1, -1, FillZero, 1'b1, 16'd5805);
    queue_header(32'h0000_0007, 0, 0, 0, 6, FillRandom, 1'b1, 16'd2477);
    queue_header(32'h0000_0008, 0, 0, 4, 5, FillRandom, 1'b1, 16'd2412);
    queue_header(32'h0000_3FFF, 0, 0, 65535, 20, FillRandom, 1'b1, 16'd5745);
    queue_header(32'h0000_3FFF, 2, 0, -1, -1, FillRandom, 1'b1, 16'd5170);
    queue_header(32'h0000_0001, 0, -3, -1, -1, FillRandom, 1'b1, 16'd0);
    queue_header(32'h7FFF_C000, 0, 0, -1, -1, FillRandom, 1'b1, 16'd0);
    queue_header(32'h0000_0008, 0, 0, -1, -1, FillRandom, 1'b1, 16'd2413);
    queue_header(32'h0000_0804, 0, 0, -1, 40, FillRandom, 1'b1, 16'd0);
    queue_header(32'h0000_0060, 0, 0, -1, -1, FillOnes, 1'b1, 16'd0);
    queue_header(32'h0000_0060, 0, 0, -1, -1, FillZero, 1'b1, 16'd0);
    queue_header(32'h0000_3FFF, 1, 0, -1, 20, FillRandom, 1'b1, 16'd5320);
    repeat (4) push_beat(8'($urandom), 1'b0);
    queue_random(293);
    while (pending_beats.size() != 0) @(posedge clk);

    send_idle_pct = 55;
    recv_idle_pct = 16;
    queue_random(293);
    while (pending_beats.size() != 0) @(posedge clk);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(292);

    while (beats_in != bytes_queued) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("covered %0d headers (%0d byte beats) under three idle mixes",
             headers_queued, beats_in);
    $display("%0d result beats compared field by field, %0d mismatches",
             results_checked, err_count);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
